// ===== hdl/vcd_pkg.sv =====
// vcd_pkg: shared types, constants and curve tables for the volume curve block
// used by vcd_seg and volume_curve_with_deadband; no dependencies
`default_nettype none

package vcd_pkg;

  // curve table geometry
  localparam int unsigned MAX_POINTS = 32;
  localparam int unsigned TBL_IDX_W  = 5;
  localparam int unsigned LEVEL_W    = 8;

  typedef logic [TBL_IDX_W-1:0] tbl_idx_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  // configuration register indexes
  localparam logic REG_DEADBAND = 1'b0;
  localparam logic REG_OFFSET   = 1'b1;

  // configuration reset values
  localparam logic [3:0] DEADBAND_RST = 4'd1;
  localparam logic [3:0] OFFSET_RST   = 4'd4;

  // segment search result handed to the sequencer
  typedef struct packed {
    logic   direct;   // y_base is the answer, no interpolation
    level_t y_base;   // y of the segment start
    level_t dy;       // rise of the segment
    level_t dx;       // run of the segment
    level_t px;       // distance of x into the segment
  } seg_res_t;

  // breakpoint x values, unused entries read as zero
  function automatic level_t curve_x(input tbl_idx_t idx);
    level_t v;
    case (idx)
      5'd0:    v = 8'd0;
      5'd1:    v = 8'd26;
      5'd2:    v = 8'd51;
      5'd3:    v = 8'd77;
      5'd4:    v = 8'd102;
      5'd5:    v = 8'd128;
      5'd6:    v = 8'd153;
      5'd7:    v = 8'd179;
      5'd8:    v = 8'd204;
      5'd9:    v = 8'd230;
      5'd10:   v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // breakpoint y values, unused entries read as zero
  function automatic level_t curve_y(input tbl_idx_t idx);
    level_t v;
    case (idx)
      5'd0:    v = 8'd0;
      5'd1:    v = 8'd94;
      5'd2:    v = 8'd140;
      5'd3:    v = 8'd171;
      5'd4:    v = 8'd189;
      5'd5:    v = 8'd207;
      5'd6:    v = 8'd217;
      5'd7:    v = 8'd230;
      5'd8:    v = 8'd240;
      5'd9:    v = 8'd250;
      5'd10:   v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vcd_seg.sv =====
// vcd_seg: serial segment search over the curve breakpoints, one compare a cycle
// depends on vcd_pkg for the curve tables and the result struct
`default_nettype none

module vcd_seg #(
  parameter int unsigned CURVE_POINTS = 11
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire vcd_pkg::level_t  x_i,
  output logic                  done_o,
  output vcd_pkg::seg_res_t     res_o
);
  import vcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(CURVE_POINTS);
  localparam logic [IDX_W-1:0] START_IDX = IDX_W'(CURVE_POINTS - 2);
  localparam tbl_idx_t LAST_IDX  = tbl_idx_t'(CURVE_POINTS - 1);
  localparam tbl_idx_t FIRST_IDX = tbl_idx_t'(0);

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  level_t           x_q;

  tbl_idx_t idx_w;
  tbl_idx_t idx_nx;
  level_t   xi;
  level_t   xn;
  logic     below;
  logic     above;
  logic     step;

  // table reads for the current candidate segment
  always_comb begin
    idx_w  = tbl_idx_t'(idx_q);
    idx_nx = idx_w + tbl_idx_t'(1);
    xi     = curve_x(idx_w);
    xn     = curve_x(idx_nx);
    below  = x_q <= curve_x(FIRST_IDX);
    above  = x_q >= curve_x(LAST_IDX);
    step   = (idx_q != '0) && (x_q < xi);
    done_o = busy_q && (below || above || !step);
  end

  // segment result: clamp at either end, exact hit, or interpolation operands
  always_comb begin
    res_o = '0;
    if (below) begin
      res_o.direct = 1'b1;
      res_o.y_base = curve_y(FIRST_IDX);
    end else if (above) begin
      res_o.direct = 1'b1;
      res_o.y_base = curve_y(LAST_IDX);
    end else begin
      res_o.direct = (x_q == xi) || (xn <= xi);
      res_o.y_base = curve_y(idx_w);
      res_o.dy     = curve_y(idx_nx) - curve_y(idx_w);
      res_o.dx     = xn - xi;
      res_o.px     = x_q - xi;
    end
  end

  // search walks down from the last inner segment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= START_IDX;
    end else if (busy_q) begin
      if (done_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q - IDX_W'(1);
      end
    end
  end

  // operand latch
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vcd_div.sv =====
// vcd_div: restoring divider, one quotient bit a cycle, 8-bit quotient
// depends on nothing but the caller's guarantee that the quotient fits 8 bits
`default_nettype none

module vcd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [7:0]  divisor_i,
  output logic             done_o,
  output logic [7:0]       quotient_o
);

  logic       busy_q;
  logic       done_q;
  logic [2:0] cnt_q;
  logic [7:0] rem_q;
  logic [7:0] dvd_q;
  logic [7:0] dsr_q;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, dvd_q[7]};
    diff  = trial - {1'b0, dsr_q};
    fits  = trial >= {1'b0, dsr_q};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd7);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: high byte starts as remainder, quotient bits shift into dvd_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[15:8];
      dvd_q <= dividend_i[7:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[7:0] : trial[7:0];
      dvd_q <= {dvd_q[6:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

// ===== hdl/volume_curve_with_deadband.sv =====
// volume_curve_with_deadband: top level with APB registers, deadband and sequencer
// depends on vcd_pkg, vcd_seg and vcd_div
`default_nettype none

// Each sample word is cut to 8 bits and checked against the held level and the
// deadband; unless the word is muted, both gains are then looked up on the
// piecewise-linear curve, right channel first, left second. One sequencer drives
// a single segment-search unit and a single bit-serial divider for both lookups,
// so the block takes one word at a time and stalls its input until the result
// sits in the output register. Per channel the search walks the segments; a
// point on a breakpoint or clamped is done there, an interpolated point goes on
// through a multiply state and the divider. A muted word goes straight to the
// output state. The held level is updated on muted words too. Registers:
// deadband at byte address 0, channel_offset at byte address 4, both 4 bits wide.
module volume_curve_with_deadband #(
  parameter int unsigned CURVE_POINTS = 11
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [9:0]  adc_sample_i,
  input  wire logic        mute_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       right_gain_o,
  output logic [7:0]       left_gain_o
);
  import vcd_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEG_GO   = 3'd1;
  localparam logic [2:0] S_SEG_WAIT = 3'd2;
  localparam logic [2:0] S_MUL      = 3'd3;
  localparam logic [2:0] S_DIV_WAIT = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] deadband_q;
  logic [3:0] offset_q;
  level_t     held_q;
  logic       mute_q;
  logic       phase_q, phase_d;
  seg_res_t   seg_res_q;
  level_t     right_q;
  level_t     left_q;
  logic       out_valid_q;
  level_t     right_gain_q;
  level_t     left_gain_q;

  logic       cfg_wr;
  logic       in_acc;
  level_t     level;
  level_t     diff;
  logic       exceed;
  logic [8:0] left_sum;
  level_t     left_idx;
  level_t     seg_x;
  logic       seg_start;
  logic       seg_done;
  seg_res_t   seg_res;
  logic       div_start;
  logic       div_done;
  logic [7:0] quotient;
  logic       fin;
  level_t     fin_val;
  logic       out_load;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      offset_q   <= OFFSET_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DEADBAND: deadband_q <= pwdata[3:0];
        REG_OFFSET:   offset_q   <= pwdata[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEADBAND: prdata = {28'd0, deadband_q};
      REG_OFFSET:   prdata = {28'd0, offset_q};
      default:      prdata = '0;
    endcase
  end

  // deadband compare on the incoming word
  always_comb begin
    level  = adc_sample_i[9:2];
    diff   = (level >= held_q) ? (level - held_q) : (held_q - level);
    exceed = diff > {4'd0, deadband_q};
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // left index saturates at full scale
  always_comb begin
    left_sum = {1'b0, held_q} + {5'd0, offset_q};
    left_idx = left_sum[8] ? 8'hFF : left_sum[7:0];
    seg_x    = phase_q ? left_idx : held_q;
  end

  vcd_seg #(
    .CURVE_POINTS(CURVE_POINTS)
  ) u_seg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(seg_start),
    .x_i    (seg_x),
    .done_o (seg_done),
    .res_o  (seg_res)
  );

  vcd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({8'd0, seg_res_q.dy} * {8'd0, seg_res_q.px}),
    .divisor_i (seg_res_q.dx),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    seg_start = 1'b0;
    div_start = 1'b0;
    fin       = 1'b0;
    fin_val   = seg_res_q.y_base;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        phase_d = 1'b0;
        if (in_acc) begin
          state_d = mute_i ? S_OUT : S_SEG_GO;
        end
      end
      S_SEG_GO: begin
        seg_start = 1'b1;
        state_d   = S_SEG_WAIT;
      end
      S_SEG_WAIT: begin
        if (seg_done) begin
          if (seg_res.direct) begin
            fin     = 1'b1;
            fin_val = seg_res.y_base;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          fin     = 1'b1;
          fin_val = quotient + seg_res_q.y_base;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // channel finished: go on to the left channel or to the output
    if (fin) begin
      if (!phase_q) begin
        phase_d = 1'b1;
        state_d = S_SEG_GO;
      end else begin
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (in_acc && exceed) begin
        held_q <= level;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mute_q <= mute_i;
    end
    if (seg_done) begin
      seg_res_q <= seg_res;
    end
    if (fin && !phase_q) begin
      right_q <= fin_val;
    end
    if (fin && phase_q) begin
      left_q <= fin_val;
    end
    if (out_load) begin
      right_gain_q <= mute_q ? '0 : right_q;
      left_gain_q  <= mute_q ? '0 : left_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign right_gain_o = right_gain_q;
  assign left_gain_o  = left_gain_q;

  // an accepted word always starts the sequencer
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("sequencer idle after accepted word");

  // a level change beyond the deadband is taken over
  a_held_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && exceed) |=> held_q == $past(level))
    else $error("held level not updated");

  // a muted word gives zero gains
  a_mute_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && mute_q) |=> (right_gain_o == '0) && (left_gain_o == '0))
    else $error("muted word with nonzero gain");

  // the divider only reports back while the sequencer waits on it
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("divider done outside its wait state");

endmodule

`default_nettype wire
